FILE: rtl/core/otbd_pkg.sv
// Shared constants and types of the octal tree bitmap decoder.
`default_nettype none

package otbd_pkg;

  localparam int unsigned MAX_LEVELS = 6;
  localparam int unsigned STACK_DEPTH = MAX_LEVELS - 1;
  localparam int unsigned LVL_W = 3;
  localparam int unsigned DEPTH_W = 3;
  localparam int unsigned CUR_W = 4;
  localparam int unsigned POS_W = 15;
  localparam int unsigned BYTE_W = 8;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SETTLE
  } otbd_state_e;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;
    logic step;
    logic finish;
  } otbd_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic stop;
    logic out_free;
  } otbd_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/otbd_ctrl.sv
// Controller state machine of the octal tree bitmap decoder.
`default_nettype none

module otbd_ctrl import otbd_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_ready_o,
  input  wire otbd_stat_t stat_i,
  output otbd_cmd_t       cmd_o
);

  otbd_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = ST_SETTLE;
        end
      end
      ST_SETTLE: begin
        if (!stat_i.stop) begin
          cmd_o.step = 1'b1;
        end else if (stat_i.out_free) begin
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/otbd_datapath.sv
// Datapath of the octal tree bitmap decoder: level stack, position and result register.
`default_nettype none

module otbd_datapath import otbd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [LVL_W-1:0]  cfg_data_i,
  input  wire logic [BYTE_W-1:0] tree_byte_i,
  input  wire otbd_cmd_t         cmd_i,
  output otbd_stat_t             stat_o,
  input  wire logic              out_ready_i,
  output logic                   out_valid_o,
  output logic                   is_leaf_o,
  output logic [POS_W-1:0]       byte_index_o,
  output logic [BYTE_W-1:0]      hit_bits_o,
  output logic                   tree_done_o
);

  logic [LVL_W-1:0]   levels_q;
  logic [DEPTH_W-1:0] depth_q, depth_d;
  logic [POS_W-1:0]   pos_q, pos_d;
  logic [BYTE_W-1:0]  mask_q [STACK_DEPTH];
  logic [CUR_W-1:0]   cur_q [STACK_DEPTH];
  logic [CUR_W-1:0]   cur_d [STACK_DEPTH];

  logic               pend_leaf_q;
  logic [POS_W-1:0]   pend_idx_q;
  logic [BYTE_W-1:0]  pend_hits_q;

  logic               out_valid_q;
  logic               leaf_q;
  logic [POS_W-1:0]   idx_q;
  logic [BYTE_W-1:0]  hits_q;
  logic               done_q;

  logic [DEPTH_W-1:0] top;
  logic [BYTE_W-1:0]  top_mask;
  logic [CUR_W-1:0]   top_cur;
  logic               top_bit;
  logic               is_leaf_item;
  logic [POS_W-1:0]   skip;
  logic [LVL_W:0]     skip_exp;
  logic [LVL_W-1:0]   cfg_levels;

  assign top = depth_q - DEPTH_W'(1);

  always_comb begin
    top_mask = '0;
    top_cur = '0;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      if (top == DEPTH_W'(i)) begin
        top_mask = mask_q[i];
        top_cur = cur_q[i];
      end
    end
  end

  assign top_bit = ~top_cur[CUR_W-1] & top_mask[top_cur[CUR_W-2:0]];
  assign stat_o.stop = (depth_q == '0) || top_bit;
  assign stat_o.out_free = ~out_valid_q | out_ready_i;

  // A leaf sits one level below the deepest open interior node.
  assign is_leaf_item = ({1'b0, depth_q} + (DEPTH_W + 1)'(1)) >= {1'b0, levels_q};

  // A missing child of the top node covers 8^(levels - depth - 1) vector bytes.
  assign skip_exp = {1'b0, levels_q} - {1'b0, depth_q} - (LVL_W + 1)'(1);
  always_comb begin
    if (levels_q <= depth_q) begin
      skip = POS_W'(1);
    end else begin
      skip = POS_W'(1) << (skip_exp * (LVL_W + 1)'(3));
    end
  end

  // Out-of-range level counts saturate into 1..MAX_LEVELS.
  always_comb begin
    if (cfg_data_i == '0) begin
      cfg_levels = LVL_W'(1);
    end else if (cfg_data_i > LVL_W'(MAX_LEVELS)) begin
      cfg_levels = LVL_W'(MAX_LEVELS);
    end else begin
      cfg_levels = cfg_data_i;
    end
  end

  always_comb begin
    depth_d = depth_q;
    pos_d = pos_q;
    for (int i = 0; i < STACK_DEPTH; i++) begin
      cur_d[i] = cur_q[i];
    end
    if (cmd_i.accept) begin
      if (is_leaf_item) begin
        pos_d = pos_q + POS_W'(1);
        for (int i = 0; i < STACK_DEPTH; i++) begin
          if (depth_q != '0 && top == DEPTH_W'(i)) begin
            cur_d[i] = cur_q[i] + CUR_W'(1);
          end
        end
      end else begin
        depth_d = depth_q + DEPTH_W'(1);
        for (int i = 0; i < STACK_DEPTH; i++) begin
          if (depth_q == DEPTH_W'(i)) begin
            cur_d[i] = '0;
          end
        end
      end
    end else if (cmd_i.step) begin
      if (!top_cur[CUR_W-1]) begin
        // Skip a missing child of the top node.
        pos_d = pos_q + skip;
        for (int i = 0; i < STACK_DEPTH; i++) begin
          if (top == DEPTH_W'(i)) begin
            cur_d[i] = cur_q[i] + CUR_W'(1);
          end
        end
      end else begin
        // Top node exhausted: pop it and advance its parent.
        depth_d = top;
        for (int i = 0; i < STACK_DEPTH; i++) begin
          if (top != '0 && top - DEPTH_W'(1) == DEPTH_W'(i)) begin
            cur_d[i] = cur_q[i] + CUR_W'(1);
          end
        end
      end
    end else if (cmd_i.finish && depth_q == '0) begin
      pos_d = '0;
    end
    if (cfg_we_i) begin
      depth_d = '0;
      pos_d = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      levels_q <= LVL_W'(1);
      depth_q <= '0;
      pos_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        levels_q <= cfg_levels;
      end
      depth_q <= depth_d;
      pos_q <= pos_d;
      if (cmd_i.finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < STACK_DEPTH; i++) begin
      cur_q[i] <= cur_d[i];
      if (cmd_i.accept && !is_leaf_item && depth_q == DEPTH_W'(i)) begin
        mask_q[i] <= tree_byte_i;
      end
    end
    if (cmd_i.accept) begin
      pend_leaf_q <= is_leaf_item;
      pend_idx_q <= is_leaf_item ? pos_q : '0;
      pend_hits_q <= is_leaf_item ? tree_byte_i : '0;
    end
    if (cmd_i.finish) begin
      leaf_q <= pend_leaf_q;
      idx_q <= pend_idx_q;
      hits_q <= pend_hits_q;
      done_q <= (depth_q == '0);
    end
  end

  assign out_valid_o = out_valid_q;
  assign is_leaf_o = leaf_q;
  assign byte_index_o = idx_q;
  assign hit_bits_o = hits_q;
  assign tree_done_o = done_q;

endmodule

`default_nettype wire

FILE: rtl/core/octal_tree_bitmap_decoder.sv
// Top level of the octal tree bitmap decoder.
// Walk: after a request is accepted, the settle walk skips missing children of the top node and pops
// exhausted levels until a present child or an empty stack is found, then moves the result out.
// Flow: one request at a time; the settle walk does one skip or one pop per cycle, and a result still
// held in the output register stalls the next one.
// Reset clears the walk state and sets the level count to 1; a register write also clears the walk.
`default_nettype none

module octal_tree_bitmap_decoder import otbd_pkg::*; (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              cfg_we_i,
  input  wire logic [LVL_W-1:0]  cfg_data_i,
  input  wire logic              in_valid_i,
  output logic                   in_ready_o,
  input  wire logic [BYTE_W-1:0] tree_byte_i,
  output logic                   out_valid_o,
  input  wire logic              out_ready_i,
  output logic                   is_leaf_o,
  output logic [POS_W-1:0]       byte_index_o,
  output logic [BYTE_W-1:0]      hit_bits_o,
  output logic                   tree_done_o
);

  otbd_cmd_t  cmd;
  otbd_stat_t stat;

  // The controller accepts a byte, lets the datapath walk the stack until a present child
  // or an empty stack is found, then moves the result into the output register.
  otbd_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // The datapath holds the level masks and cursors, the vector position and the
  // output register, which lets the next request enter while a result waits.
  otbd_datapath u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_data_i   (cfg_data_i),
    .tree_byte_i  (tree_byte_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_ready_i  (out_ready_i),
    .out_valid_o  (out_valid_o),
    .is_leaf_o    (is_leaf_o),
    .byte_index_o (byte_index_o),
    .hit_bits_o   (hit_bits_o),
    .tree_done_o  (tree_done_o)
  );

endmodule

`default_nettype wire
